// ----- src/assert_macros.svh -----
// Assertion helpers, clocked on clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define IET_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked on every edge, reset included.
`define IET_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ----- src/iet_pkg.sv -----
package iet_pkg;

  localparam int unsigned TABLE_DEPTH = 128;
  localparam int unsigned IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [3:0] IP_VERSION_4      = 4'd4;
  localparam logic [3:0] MIN_HDR_WORDS     = 4'd5;
  localparam logic [7:0] PROTO_ICMP        = 8'd1;
  localparam logic [7:0] PROTO_TCP         = 8'd6;
  localparam logic [7:0] ICMP_ECHO_REPLY   = 8'd0;
  localparam logic [7:0] ICMP_ECHO_REQUEST = 8'd8;

  typedef enum logic [3:0] {
    V_BAD_IP_HLEN  = 4'd0,
    V_RESERVED     = 4'd1,
    V_VERSION      = 4'd2,
    V_TTL_ZERO     = 4'd3,
    V_BAD_LEN      = 4'd4,
    V_BAD_TCP_HLEN = 4'd5,
    V_TCP_OK       = 4'd6,
    V_OTHER_PROTO  = 4'd7,
    V_BAD_CODE     = 4'd8,
    V_BAD_SUM      = 4'd9,
    V_BAD_TYPE     = 4'd10,
    V_STORED       = 4'd11,
    V_FULL         = 4'd12,
    V_UNKNOWN      = 4'd13,
    V_MATCHED      = 4'd14
  } verdict_t;

  typedef enum logic [1:0] {
    OP_FINAL   = 2'd0,
    OP_REQUEST = 2'd1,
    OP_REPLY   = 2'd2
  } op_t;

  typedef struct packed {
    op_t         op;
    verdict_t    verdict;
    logic [15:0] identifier;
    logic [31:0] address;
  } qitem_t;

  function automatic logic [IDX_W-1:0] lowest_set(input logic [TABLE_DEPTH-1:0] v);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (v[i]) idx = IDX_W'(i);
    end
    return idx;
  endfunction

endpackage

// ----- src/iet_in_if.sv -----
interface iet_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  ip_version;
  logic [3:0]  ip_header_words;
  logic        reserved_flag;
  logic [7:0]  ttl;
  logic [15:0] total_length;
  logic [7:0]  protocol;
  logic [3:0]  tcp_data_offset;
  logic [7:0]  msg_type;
  logic [7:0]  msg_code;
  logic        icmp_checksum_ok;
  logic [15:0] echo_id;
  logic [31:0] source_address;

  modport source (
    output valid, ip_version, ip_header_words, reserved_flag, ttl, total_length,
           protocol, tcp_data_offset, msg_type, msg_code, icmp_checksum_ok,
           echo_id, source_address,
    input  ready
  );

  modport sink (
    input  valid, ip_version, ip_header_words, reserved_flag, ttl, total_length,
           protocol, tcp_data_offset, msg_type, msg_code, icmp_checksum_ok,
           echo_id, source_address,
    output ready
  );
endinterface

// ----- src/iet_out_if.sv -----
interface iet_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  verdict;
  logic [31:0] stored_address;

  modport source (
    output valid, verdict, stored_address,
    input  ready
  );

  modport sink (
    input  valid, verdict, stored_address,
    output ready
  );
endinterface

// ----- src/iet_front.sv -----
module iet_front (
  iet_in_if.sink          in_ch,
  output logic            push_valid,
  input  logic            push_ready,
  output iet_pkg::qitem_t push_item
);

  logic [15:0] hdr_bytes;

  assign hdr_bytes   = {10'd0, in_ch.ip_header_words, 2'b00};
  assign push_valid  = in_ch.valid;
  assign in_ch.ready = push_ready;

  always_comb begin
    push_item.op         = iet_pkg::OP_FINAL;
    push_item.verdict    = iet_pkg::V_STORED;
    push_item.identifier = in_ch.echo_id;
    push_item.address    = in_ch.source_address;
    if (in_ch.ip_header_words < iet_pkg::MIN_HDR_WORDS) begin
      push_item.verdict = iet_pkg::V_BAD_IP_HLEN;
    end else if (in_ch.reserved_flag) begin
      push_item.verdict = iet_pkg::V_RESERVED;
    end else if (in_ch.ip_version != iet_pkg::IP_VERSION_4) begin
      push_item.verdict = iet_pkg::V_VERSION;
    end else if (in_ch.ttl == 8'd0) begin
      push_item.verdict = iet_pkg::V_TTL_ZERO;
    end else if (in_ch.total_length <= hdr_bytes) begin
      push_item.verdict = iet_pkg::V_BAD_LEN;
    end else if (in_ch.protocol == iet_pkg::PROTO_TCP) begin
      push_item.verdict = (in_ch.tcp_data_offset < iet_pkg::MIN_HDR_WORDS) ?
                          iet_pkg::V_BAD_TCP_HLEN : iet_pkg::V_TCP_OK;
    end else if (in_ch.protocol != iet_pkg::PROTO_ICMP) begin
      push_item.verdict = iet_pkg::V_OTHER_PROTO;
    end else if (in_ch.msg_code != 8'd0) begin
      push_item.verdict = iet_pkg::V_BAD_CODE;
    end else if (!in_ch.icmp_checksum_ok) begin
      push_item.verdict = iet_pkg::V_BAD_SUM;
    end else if (in_ch.msg_type == iet_pkg::ICMP_ECHO_REQUEST) begin
      push_item.op = iet_pkg::OP_REQUEST;
    end else if (in_ch.msg_type == iet_pkg::ICMP_ECHO_REPLY) begin
      push_item.op = iet_pkg::OP_REPLY;
    end else begin
      push_item.verdict = iet_pkg::V_BAD_TYPE;
    end
  end

endmodule

// ----- src/iet_queue.sv -----
`include "assert_macros.svh"

module iet_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  iet_pkg::qitem_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output iet_pkg::qitem_t pop_item
);

  iet_pkg::qitem_t               entry_r [iet_pkg::QUEUE_DEPTH];
  logic [iet_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [iet_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [iet_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;
  logic                          push_fire;
  logic                          pop_fire;

  assign push_ready = (cnt_r != iet_pkg::QCNT_W'(iet_pkg::QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = entry_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_fire) begin
      wr_ptr_nxt = (wr_ptr_r == iet_pkg::QPTR_W'(iet_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (pop_fire) begin
      rd_ptr_nxt = (rd_ptr_r == iet_pkg::QPTR_W'(iet_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push_fire && !pop_fire) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_fire && !push_fire) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) entry_r[wr_ptr_r] <= push_item;
  end

  `IET_ASSERT(a_q_cnt_bound, cnt_r <= iet_pkg::QCNT_W'(iet_pkg::QUEUE_DEPTH), "queue overfilled")

endmodule

// ----- src/iet_back.sv -----
`include "assert_macros.svh"

module iet_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  iet_pkg::qitem_t pop_item,
  iet_out_if.source       out_ch
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_PICK = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  state_t                         st_r, st_nxt;
  logic [iet_pkg::TABLE_DEPTH-1:0] valid_r;
  logic [15:0]                    id_cell [iet_pkg::TABLE_DEPTH];
  logic [31:0]                    addr_mem [iet_pkg::TABLE_DEPTH];
  logic [iet_pkg::TABLE_DEPTH-1:0] vec_r, vec_nxt;
  logic [iet_pkg::IDX_W-1:0]      idx_r, pick_idx;
  logic                           found_r;
  logic [31:0]                    rdata_r;
  iet_pkg::op_t                   op_r;
  logic [15:0]                    id_r;
  logic [31:0]                    addr_r;

  logic                           out_valid_r;
  iet_pkg::verdict_t              out_verdict_r, out_verdict_nxt;
  logic [31:0]                    out_addr_r, out_addr_nxt;
  logic                           out_free;
  logic                           out_load;
  logic                           pop_fire;
  logic                           exec_fire;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign pop_ready = (st_r == S_IDLE) && out_free;
  assign pop_fire  = pop_valid && pop_ready;
  assign exec_fire = (st_r == S_EXEC) && out_free;
  assign out_load  = (pop_fire && (pop_item.op == iet_pkg::OP_FINAL)) || exec_fire;
  assign pick_idx  = iet_pkg::lowest_set(vec_r);

  assign out_ch.valid          = out_valid_r;
  assign out_ch.verdict        = out_verdict_r;
  assign out_ch.stored_address = out_addr_r;

  // per-slot compare: free slots for a request, live matching slots for a reply
  always_comb begin
    for (int i = 0; i < iet_pkg::TABLE_DEPTH; i++) begin
      vec_nxt[i] = (pop_item.op == iet_pkg::OP_REQUEST) ? !valid_r[i] :
                   (valid_r[i] && (id_cell[i] == pop_item.identifier));
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: begin
        if (pop_fire && (pop_item.op != iet_pkg::OP_FINAL)) st_nxt = S_PICK;
      end
      S_PICK: st_nxt = S_EXEC;
      S_EXEC: begin
        if (out_free) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_verdict_nxt = pop_item.verdict;
    out_addr_nxt    = '0;
    if (st_r == S_EXEC) begin
      case (op_r)
        iet_pkg::OP_REQUEST: begin
          out_verdict_nxt = found_r ? iet_pkg::V_STORED : iet_pkg::V_FULL;
        end
        iet_pkg::OP_REPLY: begin
          out_verdict_nxt = found_r ? iet_pkg::V_MATCHED : iet_pkg::V_UNKNOWN;
          out_addr_nxt    = found_r ? rdata_r : 32'd0;
        end
        default: out_verdict_nxt = iet_pkg::V_BAD_TYPE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (exec_fire && found_r) begin
        valid_r[idx_r] <= (op_r == iet_pkg::OP_REQUEST);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_fire) begin
      op_r   <= pop_item.op;
      id_r   <= pop_item.identifier;
      addr_r <= pop_item.address;
      vec_r  <= vec_nxt;
    end
    if (st_r == S_PICK) begin
      idx_r   <= pick_idx;
      found_r <= |vec_r;
      rdata_r <= addr_mem[pick_idx];
    end
    if (exec_fire && found_r && (op_r == iet_pkg::OP_REQUEST)) begin
      id_cell[idx_r]  <= id_r;
      addr_mem[idx_r] <= addr_r;
    end
    if (out_load) begin
      out_verdict_r <= out_verdict_nxt;
      out_addr_r    <= out_addr_nxt;
    end
  end

  `IET_ASSERT(a_addr_only_on_match, out_valid_r && (out_verdict_r != iet_pkg::V_MATCHED) |-> out_addr_r == 32'd0, "address on non-matched item")
  `IET_ASSERT(a_store_to_free, exec_fire && found_r && (op_r == iet_pkg::OP_REQUEST) |-> !valid_r[idx_r], "request overwrote live slot")
  `IET_ASSERT(a_free_live_match, exec_fire && found_r && (op_r == iet_pkg::OP_REPLY) |-> valid_r[idx_r] && (id_cell[idx_r] == id_r), "reply freed wrong slot")
  `IET_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid_r && (st_r == S_IDLE), "reset left back end busy")

endmodule

// ----- src/icmp_echo_tracking_filter.sv -----
// Path: an item settled by header checks passes through the queue and the output register;
// echo request and echo reply items also pass the PICK and EXEC states of the table engine.
// Throughput: one header-settled item per cycle while the output is not stalled; an echo
// item holds the table engine (slot compare, lowest-slot pick with address read, write-back).
// Reset: rst_n synchronous, active low; clears all slot valid bits, queue and output at once.
module icmp_echo_tracking_filter (
  input  logic       clk,
  input  logic       rst_n,
  iet_in_if.sink     in_ch,
  iet_out_if.source  out_ch
);

  logic            push_valid;
  logic            push_ready;
  iet_pkg::qitem_t push_item;
  logic            pop_valid;
  logic            pop_ready;
  iet_pkg::qitem_t pop_item;

  iet_front u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  iet_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  iet_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_ch    (out_ch)
  );

endmodule

// ----- tb/tb_icmp_echo_tracking_filter.sv -----
module tb_icmp_echo_tracking_filter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MIN_HDR_BYTES = 20;
  localparam int RESET_CYCLES = 10;
  localparam int DRAIN_CYCLES = 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEMS_PER_PHASE = 140;
  localparam int ID_POOL_SIZE = 16;

  typedef struct packed {
    bit [3:0]  ip_version;
    bit [3:0]  ip_header_words;
    bit        reserved_flag;
    bit [7:0]  ttl;
    bit [15:0] total_length;
    bit [7:0]  protocol;
    bit [3:0]  tcp_data_offset;
    bit [7:0]  msg_type;
    bit [7:0]  msg_code;
    bit        icmp_checksum_ok;
    bit [15:0] echo_id;
    bit [31:0] source_address;
  } packet_t;

  typedef struct {
    iet_pkg::verdict_t verdict;
    bit [31:0]         stored_address;
  } expected_verdict_t;

  class echo_verdict_tracker;
    bit                slot_used[iet_pkg::TABLE_DEPTH];
    bit [15:0]         slot_id[iet_pkg::TABLE_DEPTH];
    bit [31:0]         slot_addr[iet_pkg::TABLE_DEPTH];
    expected_verdict_t pending_verdicts[$];
    int                errors;

    function void note_packet(packet_t p);
      iet_pkg::verdict_t v;
      bit [31:0]         addr;
      int                hdr_bytes;
      addr = '0;
      hdr_bytes = int'(p.ip_header_words) * 4;
      if (hdr_bytes < MIN_HDR_BYTES) v = iet_pkg::V_BAD_IP_HLEN;
      else if (p.reserved_flag) v = iet_pkg::V_RESERVED;
      else if (p.ip_version != iet_pkg::IP_VERSION_4) v = iet_pkg::V_VERSION;
      else if (p.ttl == 0) v = iet_pkg::V_TTL_ZERO;
      else if (int'(p.total_length) <= hdr_bytes) v = iet_pkg::V_BAD_LEN;
      else if (p.protocol == iet_pkg::PROTO_TCP) begin
        v = (int'(p.tcp_data_offset) * 4 < MIN_HDR_BYTES) ?
            iet_pkg::V_BAD_TCP_HLEN : iet_pkg::V_TCP_OK;
      end else if (p.protocol != iet_pkg::PROTO_ICMP) v = iet_pkg::V_OTHER_PROTO;
      else if (p.msg_code != 0) v = iet_pkg::V_BAD_CODE;
      else if (!p.icmp_checksum_ok) v = iet_pkg::V_BAD_SUM;
      else if (p.msg_type == iet_pkg::ICMP_ECHO_REQUEST) begin
        v = iet_pkg::V_FULL;
        for (int i = 0; i < iet_pkg::TABLE_DEPTH; i++) begin
          if (!slot_used[i]) begin
            slot_used[i] = 1'b1;
            slot_id[i] = p.echo_id;
            slot_addr[i] = p.source_address;
            v = iet_pkg::V_STORED;
            break;
          end
        end
      end else if (p.msg_type == iet_pkg::ICMP_ECHO_REPLY) begin
        v = iet_pkg::V_UNKNOWN;
        for (int i = 0; i < iet_pkg::TABLE_DEPTH; i++) begin
          if (slot_used[i] && slot_id[i] == p.echo_id) begin
            addr = slot_addr[i];
            slot_used[i] = 1'b0;
            v = iet_pkg::V_MATCHED;
            break;
          end
        end
      end else v = iet_pkg::V_BAD_TYPE;
      pending_verdicts.push_back('{v, addr});
    endfunction

    function void check_result(logic [3:0] verdict, logic [31:0] stored_address);
      expected_verdict_t want;
      if (pending_verdicts.size() == 0) begin
        $error("unexpected result: verdict %0d, stored_address %h", verdict, stored_address);
        errors++;
        return;
      end
      want = pending_verdicts.pop_front();
      if (verdict !== want.verdict) begin
        $error("verdict: expected %0d, got %0d", want.verdict, verdict);
        errors++;
      end
      if (stored_address !== want.stored_address) begin
        $error("stored_address: expected %h, got %h", want.stored_address, stored_address);
        errors++;
      end
    endfunction

    function int pending();
      return pending_verdicts.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   idle_pct;
  int   stall_pct;
  int   quiet_cycles;

  echo_verdict_tracker tracker;
  packet_t             cur_pkt;
  bit [15:0]           id_pool[ID_POOL_SIZE];

  iet_in_if  in_bus();
  iet_out_if out_bus();

  icmp_echo_tracking_filter dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_bus),
    .out_ch(out_bus)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_bus.ready = ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) tracker.note_packet(cur_pkt);
      if (out_bus.valid && out_bus.ready) begin
        tracker.check_result(out_bus.verdict, out_bus.stored_address);
      end
    end
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[icmp_echo_tracking_filter] ERROR");
        $finish;
      end
    end
  end

  task automatic send_packet(input packet_t p);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    cur_pkt = p;
    in_bus.ip_version = p.ip_version;
    in_bus.ip_header_words = p.ip_header_words;
    in_bus.reserved_flag = p.reserved_flag;
    in_bus.ttl = p.ttl;
    in_bus.total_length = p.total_length;
    in_bus.protocol = p.protocol;
    in_bus.tcp_data_offset = p.tcp_data_offset;
    in_bus.msg_type = p.msg_type;
    in_bus.msg_code = p.msg_code;
    in_bus.icmp_checksum_ok = p.icmp_checksum_ok;
    in_bus.echo_id = p.echo_id;
    in_bus.source_address = p.source_address;
    in_bus.valid = 1'b1;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
  endtask

  function automatic packet_t echo_packet(bit [7:0] kind, bit [15:0] ident);
    packet_t p;
    p.ip_version = iet_pkg::IP_VERSION_4;
    p.ip_header_words = 4'($urandom_range(iet_pkg::MIN_HDR_WORDS, 15));
    p.reserved_flag = 1'b0;
    p.ttl = 8'($urandom_range(1, 255));
    p.total_length = 16'($urandom_range(int'(p.ip_header_words) * 4 + 1, 65535));
    p.protocol = iet_pkg::PROTO_ICMP;
    p.tcp_data_offset = 4'($urandom);
    p.msg_type = kind;
    p.msg_code = 8'd0;
    p.icmp_checksum_ok = 1'b1;
    p.echo_id = ident;
    p.source_address = $urandom;
    return p;
  endfunction

  function automatic bit [15:0] pick_id();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return id_pool[$urandom_range(0, ID_POOL_SIZE - 1)];
  endfunction

  // one header or ICMP field broken on an otherwise clean echo packet
  function automatic packet_t broken_packet();
    packet_t p;
    p = echo_packet($urandom_range(0, 1) ? iet_pkg::ICMP_ECHO_REQUEST :
                    iet_pkg::ICMP_ECHO_REPLY, pick_id());
    case ($urandom_range(0, 9))
      0: p.ip_header_words = 4'($urandom_range(0, iet_pkg::MIN_HDR_WORDS - 1));
      1: p.reserved_flag = 1'b1;
      2: p.ip_version = 4'($urandom_range(5, 19));
      3: p.ttl = 8'd0;
      4: p.total_length = 16'($urandom_range(0, int'(p.ip_header_words) * 4));
      5: p.protocol = iet_pkg::PROTO_TCP;
      6: begin
        do p.protocol = 8'($urandom);
        while (p.protocol == iet_pkg::PROTO_ICMP || p.protocol == iet_pkg::PROTO_TCP);
      end
      7: p.msg_code = 8'($urandom_range(1, 255));
      8: p.icmp_checksum_ok = 1'b0;
      default: begin
        do p.msg_type = 8'($urandom);
        while (p.msg_type == iet_pkg::ICMP_ECHO_REQUEST ||
               p.msg_type == iet_pkg::ICMP_ECHO_REPLY);
      end
    endcase
    return p;
  endfunction

  function automatic packet_t noise_packet();
    packet_t p;
    p.ip_version = 4'($urandom);
    p.ip_header_words = 4'($urandom);
    p.reserved_flag = 1'($urandom);
    p.ttl = 8'($urandom);
    p.total_length = 16'($urandom);
    p.protocol = 8'($urandom);
    p.tcp_data_offset = 4'($urandom);
    p.msg_type = 8'($urandom);
    p.msg_code = 8'($urandom);
    p.icmp_checksum_ok = 1'($urandom);
    p.echo_id = 16'($urandom);
    p.source_address = $urandom;
    return p;
  endfunction

  task automatic run_random_phase(input int idle, input int stall);
    int      r;
    packet_t p;
    idle_pct = idle;
    stall_pct = stall;
    repeat (ITEMS_PER_PHASE) begin
      r = $urandom_range(0, 99);
      if (r < 35) p = echo_packet(iet_pkg::ICMP_ECHO_REQUEST, pick_id());
      else if (r < 70) p = echo_packet(iet_pkg::ICMP_ECHO_REPLY, pick_id());
      else if (r < 88) p = broken_packet();
      else p = noise_packet();
      send_packet(p);
    end
  endtask

  initial begin
    packet_t p;
    tracker = new;
    quiet_cycles = 0;
    idle_pct = 0;
    stall_pct = 0;
    rst_n = 1'b0;
    cur_pkt = '0;
    in_bus.valid = 1'b0;
    in_bus.ip_version = '0;
    in_bus.ip_header_words = '0;
    in_bus.reserved_flag = 1'b0;
    in_bus.ttl = '0;
    in_bus.total_length = '0;
    in_bus.protocol = '0;
    in_bus.tcp_data_offset = '0;
    in_bus.msg_type = '0;
    in_bus.msg_code = '0;
    in_bus.icmp_checksum_ok = 1'b0;
    in_bus.echo_id = '0;
    in_bus.source_address = '0;
    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hffff;
    for (int i = 2; i < ID_POOL_SIZE; i++) id_pool[i] = 16'($urandom);

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // directed: header checks in order, protocol split, ICMP checks, table basics
    p = noise_packet(); p.ip_header_words = 4'd0; send_packet(p);
    p = echo_packet(iet_pkg::ICMP_ECHO_REQUEST, 16'h1); p.ip_header_words = 4'd4;
    send_packet(p);
    p = echo_packet(iet_pkg::ICMP_ECHO_REQUEST, 16'h0000);
    p.ip_header_words = 4'd15; p.total_length = 16'hffff; p.ttl = 8'hff;
    p.source_address = 32'h0;
    send_packet(p);
    p = echo_packet(iet_pkg::ICMP_ECHO_REQUEST, 16'h1); p.reserved_flag = 1'b1;
    send_packet(p);
    p = echo_packet(iet_pkg::ICMP_ECHO_REQUEST, 16'h1); p.ip_version = 4'd0; send_packet(p);
    p = echo_packet(iet_pkg::ICMP_ECHO_REQUEST, 16'h1); p.ip_version = 4'd15; send_packet(p);
    p = echo_packet(iet_pkg::ICMP_ECHO_REQUEST, 16'h1); p.ttl = 8'd0; send_packet(p);
    p = echo_packet(iet_pkg::ICMP_ECHO_REQUEST, 16'h1);
    p.ip_header_words = iet_pkg::MIN_HDR_WORDS; p.total_length = 16'(MIN_HDR_BYTES);
    send_packet(p);
    p = echo_packet(iet_pkg::ICMP_ECHO_REQUEST, 16'h1); p.total_length = 16'd0;
    send_packet(p);
    for (int d = 0; d < 4; d++) begin
      p = echo_packet(iet_pkg::ICMP_ECHO_REQUEST, 16'h1);
      p.protocol = iet_pkg::PROTO_TCP;
      case (d)
        0: p.tcp_data_offset = 4'd0;
        1: p.tcp_data_offset = 4'd4;
        2: p.tcp_data_offset = 4'd5;
        default: p.tcp_data_offset = 4'd15;
      endcase
      send_packet(p);
    end
    p = echo_packet(iet_pkg::ICMP_ECHO_REQUEST, 16'h1); p.protocol = 8'd0; send_packet(p);
    p = echo_packet(iet_pkg::ICMP_ECHO_REQUEST, 16'h1); p.protocol = 8'hff; send_packet(p);
    p = echo_packet(iet_pkg::ICMP_ECHO_REQUEST, 16'h1); p.msg_code = 8'hff; send_packet(p);
    p = echo_packet(iet_pkg::ICMP_ECHO_REQUEST, 16'h1); p.msg_code = 8'd1; send_packet(p);
    p = echo_packet(iet_pkg::ICMP_ECHO_REQUEST, 16'h1); p.icmp_checksum_ok = 1'b0;
    send_packet(p);
    p = echo_packet(8'hff, 16'h1); send_packet(p);
    p = echo_packet(8'd3, 16'h1); send_packet(p);
    p = echo_packet(iet_pkg::ICMP_ECHO_REQUEST, 16'hffff); p.source_address = 32'hffffffff;
    send_packet(p);
    // duplicate identifier zero, then replies free the lowest slot first
    p = echo_packet(iet_pkg::ICMP_ECHO_REQUEST, 16'h0000); p.source_address = 32'h12345678;
    send_packet(p);
    send_packet(echo_packet(iet_pkg::ICMP_ECHO_REPLY, 16'h0000));
    send_packet(echo_packet(iet_pkg::ICMP_ECHO_REPLY, 16'h0000));
    send_packet(echo_packet(iet_pkg::ICMP_ECHO_REPLY, 16'h0000));
    send_packet(echo_packet(iet_pkg::ICMP_ECHO_REPLY, 16'hffff));

    run_random_phase(0, 0);
    run_random_phase(47, 0);

    // fill the table past full, then send replies to free its slots
    repeat (iet_pkg::TABLE_DEPTH + 3) begin
      send_packet(echo_packet(iet_pkg::ICMP_ECHO_REQUEST, pick_id()));
    end
    repeat (iet_pkg::TABLE_DEPTH + 8) begin
      send_packet(echo_packet(iet_pkg::ICMP_ECHO_REPLY, pick_id()));
    end

    run_random_phase(0, 47);
    run_random_phase(22, 22);

    in_bus.valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("[icmp_echo_tracking_filter] OK");
    end else begin
      $display("[icmp_echo_tracking_filter] ERROR");
    end
    $finish;
  end

endmodule
